// ===== src/mnfw_pkg.sv =====
// ----------------------------------------------------------------------------
// mnfw_pkg: shared types and constants for the MIDI note to FM writer
// Message codes, sequencer step numbers, controller/datapath handshake structs,
// the note frequency table and the bus wait-time lookup.
// ----------------------------------------------------------------------------
package mnfw_pkg;

  localparam int unsigned VoiceCount = 6;
  localparam int unsigned VoiceW     = 3;
  localparam int unsigned StepW      = 6;
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned CfgDataW   = 64;
  localparam int unsigned PatchLen   = 38;

  // MIDI status bytes and playable key range
  localparam logic [7:0] MidiNoteOn  = 8'd144;
  localparam logic [7:0] MidiNoteOff = 8'd128;
  localparam logic [7:0] MidiSense   = 8'd254;
  localparam logic [6:0] KeyLow      = 7'd25;
  localparam logic [6:0] KeyHigh     = 7'd96;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgPatch0  = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgPatch1  = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgPatch2  = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgPatch3  = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgPatch4  = 3'd4;

  // steps of a note-on burst after the 28 operator writes
  localparam logic [StepW-1:0] StepOpEnd   = 6'd28;
  localparam logic [StepW-1:0] StepAlgo    = 6'd28;
  localparam logic [StepW-1:0] StepPan     = 6'd29;
  localparam logic [StepW-1:0] StepKeyOff  = 6'd30;
  localparam logic [StepW-1:0] StepFreqHi  = 6'd31;
  localparam logic [StepW-1:0] StepFreqLo  = 6'd32;
  localparam logic [StepW-1:0] StepKeyOn   = 6'd33;

  localparam logic [VoiceW-1:0] VoiceMax   = 3'(VoiceCount - 1);

  localparam logic [7:0] AddrKeyOnOff = 8'h28;
  localparam logic [7:0] AddrAlgo     = 8'hB0;
  localparam logic [7:0] AddrPan      = 8'hB4;
  localparam logic [7:0] AddrFreqHi   = 8'hA4;
  localparam logic [7:0] AddrFreqLo   = 8'hA0;
  localparam logic [7:0] AddrOpBase   = 8'h30;
  localparam logic [7:0] PanBoth      = 8'hC0;
  localparam logic [7:0] KeyOnAll     = 8'hF0;

  localparam logic [11:0] WaitAddrLong  = 12'd2200;
  localparam logic [11:0] WaitAddrShort = 12'd2125;
  localparam logic [16:0] WaitDataOp    = 17'd10375;
  localparam logic [16:0] WaitDataFreq  = 17'd5875;
  localparam logic [16:0] WaitDataReset = 17'd72000;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PLAY,
    ST_REL
  } state_e;

  typedef enum logic {
    EK_PLAY,
    EK_REL
  } emit_kind_e;

  typedef struct packed {
    logic             load_key;
    logic             start_play;
    logic             start_rel;
    logic             emit;
    emit_kind_e       kind;
    logic [StepW-1:0] step;
    logic             last;
  } cmd_t;

  typedef struct packed {
    logic                  key_ok;
    logic [VoiceCount-1:0] rel_mask;
    logic                  out_free;
  } sts_t;

  typedef struct packed {
    logic [11:0] addr_wait;
    logic [16:0] data_wait;
  } waits_t;

  function automatic logic [10:0] note_freq(input logic [3:0] note);
    logic [10:0] f;
    case (note)
      4'd0:    f = 11'd654;
      4'd1:    f = 11'd692;
      4'd2:    f = 11'd734;
      4'd3:    f = 11'd777;
      4'd4:    f = 11'd823;
      4'd5:    f = 11'd872;
      4'd6:    f = 11'd924;
      4'd7:    f = 11'd979;
      4'd8:    f = 11'd1038;
      4'd9:    f = 11'd1100;
      4'd10:   f = 11'd1165;
      4'd11:   f = 11'd1234;
      default: f = 11'd654;
    endcase
    return f;
  endfunction

  function automatic waits_t bus_waits(input logic [7:0] addr, input logic port);
    waits_t w;
    w.addr_wait = '0;
    w.data_wait = '0;
    if (addr > 8'h20 && addr < 8'hB7) w.addr_wait = WaitAddrLong;
    if (!port && addr > 8'h09 && addr < 8'h1E) w.addr_wait = WaitAddrShort;
    if (addr > 8'h20 && addr < 8'h9F) w.data_wait = WaitDataOp;
    if (addr > 8'h9F && addr < 8'hB7) w.data_wait = WaitDataFreq;
    if (!port) begin
      if (addr == 8'h10) w.data_wait = WaitDataReset;
      if (addr > 8'h10 && addr < 8'h1E) w.data_wait = WaitDataOp;
    end
    return w;
  endfunction

  // key-on/off channel code: the high bank skips code 3
  function automatic logic [2:0] voice_code(input logic [VoiceW-1:0] v);
    return (v > 3'd2) ? v + 3'd1 : v;
  endfunction

endpackage

// ===== src/mnfw_ctrl.sv =====
// ----------------------------------------------------------------------------
// mnfw_ctrl: MIDI parser and write sequencer
// Tracks the note-on message state, starts a note burst or a release walk and
// steps through the writes one beat at a time.
// ----------------------------------------------------------------------------
module mnfw_ctrl
  import mnfw_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] midi_byte_i,
  input  sts_t       sts_i,
  output cmd_t       cmd_o
);

  state_e           state_q, state_d;
  logic [StepW-1:0] step_q, step_d;
  logic             open_q, open_d;
  logic             keyr_q, keyr_d;
  logic [VoiceW-1:0]     vidx;
  logic [VoiceCount-1:0] mask_above;
  logic                  rel_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
      open_q  <= 1'b0;
      keyr_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      open_q  <= open_d;
      keyr_q  <= keyr_d;
    end
  end

  assign vidx       = step_q[VoiceW-1:0];
  assign mask_above = sts_i.rel_mask >> vidx;
  // last release beat when no higher voice matches
  assign rel_last   = (mask_above[VoiceCount-1:1] == '0);

  always_comb begin
    state_d    = state_q;
    step_d     = step_q;
    open_d     = open_q;
    keyr_d     = keyr_q;
    cmd_o      = '0;
    cmd_o.step = step_q;
    in_stall_o = (state_q != ST_IDLE);
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (midi_byte_i == MidiSense) begin
            // drop active sensing
          end else if (midi_byte_i == MidiNoteOn) begin
            open_d = 1'b1;
            keyr_d = 1'b0;
          end else if (midi_byte_i == MidiNoteOff) begin
            open_d = 1'b0;
            keyr_d = 1'b0;
          end else if (midi_byte_i[7] || !open_q) begin
            // drop stray bytes
          end else if (!keyr_q) begin
            keyr_d         = 1'b1;
            cmd_o.load_key = 1'b1;
          end else begin
            open_d = 1'b0;
            keyr_d = 1'b0;
            step_d = '0;
            if (midi_byte_i != 8'd0) begin
              if (sts_i.key_ok) begin
                cmd_o.start_play = 1'b1;
                state_d          = ST_PLAY;
              end
            end else begin
              cmd_o.start_rel = 1'b1;
              state_d         = ST_REL;
            end
          end
        end
      end
      ST_PLAY: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.kind = EK_PLAY;
          cmd_o.last = (step_q == StepKeyOn);
          if (step_q == StepKeyOn) begin
            state_d = ST_IDLE;
          end else begin
            step_d = step_q + 6'd1;
          end
        end
      end
      ST_REL: begin
        if (sts_i.rel_mask[vidx]) begin
          if (sts_i.out_free) begin
            cmd_o.emit = 1'b1;
            cmd_o.kind = EK_REL;
            cmd_o.last = rel_last;
            if (rel_last) begin
              state_d = ST_IDLE;
            end else begin
              step_d = step_q + 6'd1;
            end
          end
        end else if (vidx == VoiceMax) begin
          state_d = ST_IDLE;
        end else begin
          step_d = step_q + 6'd1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== src/mnfw_dp.sv =====
// ----------------------------------------------------------------------------
// mnfw_dp: voice bookkeeping and register write builder
// Holds the instrument patch, the held key, the round-robin voice pointer and
// the key of each voice, builds each register write and drives the output stage.
// ----------------------------------------------------------------------------
module mnfw_dp
  import mnfw_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [7:0]          midi_byte_i,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  cmd_t                cmd_i,
  output sts_t                sts_o,
  input  logic                out_stall_i,
  output logic                out_valid_o,
  output logic [7:0]          reg_addr_o,
  output logic [7:0]          reg_data_o,
  output logic                port_high_o,
  output logic [11:0]         addr_wait_ns_o,
  output logic [16:0]         data_wait_ns_o,
  output logic                last_o
);

  logic [3:0][63:0]          patch_q;
  logic [47:0]               patch4_q;
  logic [PatchLen*8-1:0]     pbytes;
  logic [6:0]                held_key_q;
  logic [VoiceW-1:0]         next_voice_q;
  logic [VoiceCount-1:0][6:0] voice_key_q;
  logic [VoiceCount-1:0]     mask_q, mask_now;
  logic [VoiceW-1:0]         voice_q, voice_sel;
  logic [2:0]                oct_q, oct_now;
  logic [3:0]                note_q;
  logic [6:0]                key_off;
  logic [14:0]               oct_prod;
  logic [6:0]                oct_x12;
  logic [10:0]               freq;
  logic                      out_valid_q, out_valid_d;
  logic [7:0]                addr_q, data_q, w_addr, w_data;
  logic                      port_q, last_q, w_port;
  logic [11:0]               aw_q;
  logic [16:0]               dw_q;
  logic [1:0]                chan;
  logic                      hi_bank;
  logic [3:0][7:0]           op_val;
  logic [2:0]                grp;
  logic [1:0]                opj;
  waits_t                    w_waits;

  assign pbytes = {patch4_q, patch_q[3], patch_q[2], patch_q[1], patch_q[0]};

  // patch registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      patch_q  <= '0;
      patch4_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgPatch0: patch_q[0] <= cfg_data_i;
        CfgPatch1: patch_q[1] <= cfg_data_i;
        CfgPatch2: patch_q[2] <= cfg_data_i;
        CfgPatch3: patch_q[3] <= cfg_data_i;
        CfgPatch4: patch4_q   <= cfg_data_i[47:0];
        default: begin
        end
      endcase
    end
  end

  // octave and note of key - 25: divide by 12 via reciprocal 171/2048
  assign key_off  = held_key_q - KeyLow;
  assign oct_prod = 15'(key_off) * 15'd171;
  assign oct_now  = oct_prod[13:11];
  assign oct_x12  = 7'(oct_now) * 7'd12;
  assign voice_sel = (next_voice_q < 3'(VoiceCount)) ? next_voice_q : '0;

  always_comb begin
    for (int i = 0; i < VoiceCount; i++) begin
      mask_now[i] = (voice_key_q[i] == held_key_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_key_q   <= '0;
      next_voice_q <= '0;
      voice_key_q  <= '0;
      mask_q       <= '0;
      voice_q      <= '0;
      oct_q        <= '0;
      note_q       <= '0;
    end else begin
      if (cmd_i.load_key) held_key_q <= midi_byte_i[6:0];
      if (cmd_i.start_play) begin
        voice_q                <= voice_sel;
        voice_key_q[voice_sel] <= held_key_q;
        next_voice_q           <= (voice_sel == VoiceMax) ? '0 : voice_sel + 3'd1;
        oct_q                  <= oct_now;
        note_q                 <= 4'(key_off - oct_x12);
      end
      if (cmd_i.start_rel) mask_q <= mask_now;
    end
  end

  assign sts_o.key_ok   = (held_key_q >= KeyLow) && (held_key_q <= KeyHigh);
  assign sts_o.rel_mask = mask_q;
  assign sts_o.out_free = !out_valid_q || !out_stall_i;

  // write builder
  assign hi_bank = (voice_q > 3'd2);
  assign chan    = hi_bank ? 2'(voice_q - 3'd3) : voice_q[1:0];
  assign freq    = note_freq(note_q);
  assign grp     = cmd_i.step[4:2];
  assign opj     = cmd_i.step[1:0];

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      case (grp)
        3'd0: op_val[j] = {pbytes[8*(10+9*j) +: 4], 4'b0} + pbytes[8*(9+9*j) +: 8];
        3'd1: op_val[j] = pbytes[8*(7+9*j) +: 8];
        3'd2: op_val[j] = {pbytes[8*(8+9*j) +: 2], 6'b0} + pbytes[8*(2+9*j) +: 8];
        3'd3: op_val[j] = pbytes[8*(3+9*j) +: 8];
        3'd4: op_val[j] = pbytes[8*(4+9*j) +: 8];
        3'd5: op_val[j] = {pbytes[8*(6+9*j) +: 4], 4'b0} + pbytes[8*(5+9*j) +: 8];
        default: op_val[j] = 8'd0;
      endcase
    end
  end

  always_comb begin
    w_port = hi_bank;
    w_addr = AddrKeyOnOff;
    w_data = '0;
    if (cmd_i.kind == EK_REL) begin
      w_port = 1'b0;
      w_data = 8'(voice_code(cmd_i.step[VoiceW-1:0]));
    end else if (cmd_i.step < StepOpEnd) begin
      w_addr = AddrOpBase + {1'b0, grp, 4'b0} + {4'b0, opj, 2'b0} + {6'b0, chan};
      w_data = op_val[opj];
    end else begin
      case (cmd_i.step)
        StepAlgo: begin
          w_addr = AddrAlgo + {6'b0, chan};
          w_data = {pbytes[8 +: 5], 3'b0} + pbytes[0 +: 8];
        end
        StepPan: begin
          w_addr = AddrPan + {6'b0, chan};
          w_data = PanBoth;
        end
        StepKeyOff: begin
          w_port = 1'b0;
          w_data = 8'(voice_code(voice_q));
        end
        StepFreqHi: begin
          w_addr = AddrFreqHi + {6'b0, chan};
          w_data = {2'b0, oct_q, freq[10:8]};
        end
        StepFreqLo: begin
          w_addr = AddrFreqLo + {6'b0, chan};
          w_data = freq[7:0];
        end
        StepKeyOn: begin
          w_port = 1'b0;
          w_data = KeyOnAll + 8'(voice_code(voice_q));
        end
        default: begin
          w_port = 1'b0;
        end
      endcase
    end
  end

  assign w_waits = bus_waits(w_addr, w_port);

  // output stage: load on a new beat, clear once taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.emit) out_valid_d = 1'b1;
    else if (!out_stall_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      addr_q <= w_addr;
      data_q <= w_data;
      port_q <= w_port;
      aw_q   <= w_waits.addr_wait;
      dw_q   <= w_waits.data_wait;
      last_q <= cmd_i.last;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign reg_addr_o     = addr_q;
  assign reg_data_o     = data_q;
  assign port_high_o    = port_q;
  assign addr_wait_ns_o = aw_q;
  assign data_wait_ns_o = dw_q;
  assign last_o         = last_q;

endmodule

// ===== src/midi_note_to_fm_register_writer_top.sv =====
// ----------------------------------------------------------------------------
// midi_note_to_fm_register_writer_top: MIDI note-on to FM register writes
// A byte is taken whenever the block is idle. A note-on velocity byte for a key
// in 25..96 starts a burst of 34 register writes on the next round robin voice,
// one beat per cycle from the write sequencer while the output is not stalled;
// a zero velocity walks the six voices one per cycle, waiting on an output
// stall, and emits a key-off for each voice holding the key, stopping after
// the last matching voice. Other bytes emit nothing.
// The last write caused by a byte carries last. The patch registers are written
// through the configuration port; the user must write them only while the block
// is idle, which the block itself does not enforce.
// ----------------------------------------------------------------------------
module midi_note_to_fm_register_writer_top
  import mnfw_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [7:0]          midi_byte_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [7:0]          reg_addr_o,
  output logic [7:0]          reg_data_o,
  output logic                port_high_o,
  output logic [11:0]         addr_wait_ns_o,
  output logic [16:0]         data_wait_ns_o,
  output logic                last_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  cmd_t cmd;
  sts_t sts;

  mnfw_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .midi_byte_i (midi_byte_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  mnfw_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .midi_byte_i    (midi_byte_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .out_stall_i    (out_stall_i),
    .out_valid_o    (out_valid_o),
    .reg_addr_o     (reg_addr_o),
    .reg_data_o     (reg_data_o),
    .port_high_o    (port_high_o),
    .addr_wait_ns_o (addr_wait_ns_o),
    .data_wait_ns_o (data_wait_ns_o),
    .last_o         (last_o)
  );

endmodule

// ===== src/mnfw_chk.sv =====
// ----------------------------------------------------------------------------
// mnfw_chk: port-level checks for the MIDI note to FM writer
// Watches the output beats and the input stall over time.
// ----------------------------------------------------------------------------
module mnfw_chk
  import mnfw_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [7:0]  reg_addr_o,
  input logic [7:0]  reg_data_o,
  input logic        port_high_o,
  input logic [11:0] addr_wait_ns_o,
  input logic        last_o
);

  a_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output beat dropped while stalled");

  a_payload_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(reg_addr_o) && $stable(reg_data_o))
    else $error("stalled output beat changed");

  // a burst in flight keeps the input stalled until its final beat
  a_burst_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> in_stall_o)
    else $error("input open during an unfinished burst");

  a_keyonoff_low_bank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && reg_addr_o == AddrKeyOnOff |-> !port_high_o)
    else $error("key on/off written to high bank");

  a_keyonoff_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && reg_addr_o == AddrKeyOnOff |-> addr_wait_ns_o == WaitAddrLong)
    else $error("key on/off address wait wrong");

endmodule

bind midi_note_to_fm_register_writer_top mnfw_chk u_mnfw_chk (.*);

// ===== test/mnfw_checker.sv =====
// ----------------------------------------------------------------------------
// mnfw_checker: register-write predictor and scoreboard for the MIDI FM writer
// Watches the MIDI byte channel, the configuration port and the register-write
// channel. Each accepted MIDI byte steps a local parser and voice table and
// queues the writes it must cause, config writes update a local patch, and each
// accepted write beat is compared field by field with the oldest queued write.
// ----------------------------------------------------------------------------
module mnfw_checker
  import mnfw_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  logic [7:0]          midi_byte_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  logic [7:0]          reg_addr_i,
  input  logic [7:0]          reg_data_i,
  input  logic                port_high_i,
  input  logic [11:0]         addr_wait_ns_i,
  input  logic [16:0]         data_wait_ns_i,
  input  logic                last_i,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output int unsigned         pending_o,
  output int unsigned         fail_count_o
);

  // F-number per semitone, index 0 is the lowest playable key's note
  localparam logic [11:0][10:0] NoteStep = {
    11'd1234, 11'd1165, 11'd1100, 11'd1038, 11'd979, 11'd924,
    11'd872,  11'd823,  11'd777,  11'd734,  11'd692, 11'd654
  };

  typedef struct packed {
    logic [7:0]  addr;
    logic [7:0]  data;
    logic        port;
    logic [11:0] aw;
    logic [16:0] dw;
    logic        last;
  } fm_write_t;

  logic [63:0] patch_q [5];
  logic        note_open_q;
  logic        key_seen_q;
  logic [6:0]  held_key_q;
  logic [2:0]  next_voice_q;
  logic [6:0]  voice_key_q [VoiceCount];
  fm_write_t   expected_writes [$];
  int unsigned mismatches = 0;

  function automatic logic [7:0] patch_byte(input int unsigned k);
    if (k >= PatchLen) return 8'h00;
    return patch_q[k / 8][8 * (k % 8) +: 8];
  endfunction

  function automatic fm_write_t bus_write(input logic [7:0] addr, input logic [7:0] data,
                                          input logic port);
    fm_write_t w;
    w.addr = addr;
    w.data = data;
    w.port = port;
    w.last = 1'b0;
    w.aw   = '0;
    w.dw   = '0;
    if (!port && addr inside {[8'h0A:8'h1D]}) w.aw = WaitAddrShort;
    else if (addr inside {[8'h21:8'hB6]}) w.aw = WaitAddrLong;
    if (addr inside {[8'h21:8'h9E]}) w.dw = WaitDataOp;
    else if (addr inside {[8'hA0:8'hB6]}) w.dw = WaitDataFreq;
    else if (!port && addr == 8'h10) w.dw = WaitDataReset;
    else if (!port && addr inside {[8'h11:8'h1D]}) w.dw = WaitDataOp;
    return w;
  endfunction

  task automatic predict_byte(input logic [7:0] b);
    fm_write_t   burst [$];
    fm_write_t   w;
    logic [2:0]  v;
    logic [2:0]  chan_code;
    logic [1:0]  slot;
    logic        bank;
    int unsigned span;
    logic [3:0]  note;
    logic [2:0]  octave;
    logic [10:0] fnum;
    logic [7:0]  d;
    int unsigned base;
    if (b == MidiSense) begin
      // active sensing: no effect at all
    end else if (b == MidiNoteOn) begin
      note_open_q = 1'b1;
      key_seen_q  = 1'b0;
    end else if (b == MidiNoteOff) begin
      note_open_q = 1'b0;
      key_seen_q  = 1'b0;
    end else if (b[7] || !note_open_q) begin
      // stray status or data byte: drop
    end else if (!key_seen_q) begin
      key_seen_q = 1'b1;
      held_key_q = b[6:0];
    end else begin
      note_open_q = 1'b0;
      key_seen_q  = 1'b0;
      if (b != 8'd0) begin
        if (held_key_q >= KeyLow && held_key_q <= KeyHigh) begin
          v         = (next_voice_q < VoiceCount) ? next_voice_q : 3'd0;
          bank      = (v > 3'd2);
          slot      = bank ? 2'(v - 3'd3) : v[1:0];
          chan_code = bank ? v + 3'd1 : v;
          span      = 32'(held_key_q - KeyLow);
          note      = 4'(span % 12);
          octave    = 3'(span / 12);
          fnum      = NoteStep[note];
          voice_key_q[v] = held_key_q;
          // seven operator register groups, four operators each
          for (int g = 0; g < 7; g++) begin
            for (int j = 0; j < 4; j++) begin
              base = 9 * j;
              case (g)
                0: d = 8'({patch_byte(base + 10), 4'h0} + patch_byte(base + 9));
                1: d = patch_byte(base + 7);
                2: d = 8'({patch_byte(base + 8), 6'h0} + patch_byte(base + 2));
                3: d = patch_byte(base + 3);
                4: d = patch_byte(base + 4);
                5: d = 8'({patch_byte(base + 6), 4'h0} + patch_byte(base + 5));
                default: d = 8'h00;
              endcase
              burst.push_back(bus_write(8'(AddrOpBase + 16 * g + 4 * j + slot), d, bank));
            end
          end
          burst.push_back(bus_write(AddrAlgo + slot,
                                    8'({patch_byte(1), 3'b000} + patch_byte(0)), bank));
          burst.push_back(bus_write(AddrPan + slot, PanBoth, bank));
          burst.push_back(bus_write(AddrKeyOnOff, {5'd0, chan_code}, 1'b0));
          burst.push_back(bus_write(AddrFreqHi + slot, {2'b00, octave, fnum[10:8]}, bank));
          burst.push_back(bus_write(AddrFreqLo + slot, fnum[7:0], bank));
          burst.push_back(bus_write(AddrKeyOnOff, KeyOnAll + chan_code, 1'b0));
          next_voice_q = (v == VoiceMax) ? 3'd0 : v + 3'd1;
        end
      end else begin
        // key-off every voice holding the key, never-played voices hold key 0
        for (int i = 0; i < VoiceCount; i++) begin
          if (voice_key_q[i] == held_key_q) begin
            chan_code = 3'((i > 2) ? i + 1 : i);
            burst.push_back(bus_write(AddrKeyOnOff, {5'd0, chan_code}, 1'b0));
          end
        end
      end
      for (int i = 0; i < burst.size(); i++) begin
        w      = burst[i];
        w.last = (i == burst.size() - 1);
        expected_writes.push_back(w);
      end
    end
  endtask

  task automatic report(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input int unsigned got,
                             input int unsigned want, input logic [7:0] ctx_addr);
    if (got != want)
      report($sformatf("%s of write to %02h: got %0d, expected %0d", name, ctx_addr, got,
                       want));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    fm_write_t want;
    if (!rst_ni) begin
      for (int i = 0; i < 5; i++) patch_q[i] = '0;
      for (int i = 0; i < VoiceCount; i++) voice_key_q[i] = '0;
      note_open_q  = 1'b0;
      key_seen_q   = 1'b0;
      held_key_q   = '0;
      next_voice_q = '0;
      expected_writes.delete();
      pending_o    <= 0;
      fail_count_o <= mismatches;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CfgPatch0, CfgPatch1, CfgPatch2, CfgPatch3: patch_q[cfg_index_i] = cfg_data_i;
          CfgPatch4: patch_q[4] = {16'h0000, cfg_data_i[47:0]};
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) predict_byte(midi_byte_i);
      if (out_valid_i && !out_stall_i) begin
        if (expected_writes.size() == 0) begin
          report($sformatf("write %02h <= %02h with nothing expected", reg_addr_i,
                           reg_data_i));
        end else begin
          want = expected_writes.pop_front();
          check_field("reg_addr", reg_addr_i, want.addr, want.addr);
          check_field("reg_data", reg_data_i, want.data, want.addr);
          check_field("port_high", port_high_i, want.port, want.addr);
          check_field("addr_wait_ns", addr_wait_ns_i, want.aw, want.addr);
          check_field("data_wait_ns", data_wait_ns_i, want.dw, want.addr);
          check_field("last", last_i, want.last, want.addr);
        end
      end
      pending_o    <= expected_writes.size();
      fail_count_o <= mismatches;
    end
  end

endmodule

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: MIDI note to FM register writer
// Drives MIDI byte streams (directed corner cases, then mostly well-formed
// note-on and release sequences with random keys, velocities and noise) under
// several instrument patches, with random gaps on the byte side and random
// stalls on the write side. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module testbench;
  import mnfw_pkg::*;

  localparam int unsigned CycleLimit  = 1000000;
  localparam int unsigned DrainCycles = 40;
  localparam int unsigned PhaseItems  = 86;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [7:0]          midi_byte_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic [7:0]          reg_addr_o;
  logic [7:0]          reg_data_o;
  logic                port_high_o;
  logic [11:0]         addr_wait_ns_o;
  logic [16:0]         data_wait_ns_o;
  logic                last_o;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;

  int unsigned pending_writes;
  int unsigned fail_count;
  int unsigned cycle_count = 0;
  bit          send_quiet  = 1'b0;
  bit          recv_quiet  = 1'b0;
  logic [6:0]  recent_keys [$];

  midi_note_to_fm_register_writer_top uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .midi_byte_i    (midi_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .reg_addr_o     (reg_addr_o),
    .reg_data_o     (reg_data_o),
    .port_high_o    (port_high_o),
    .addr_wait_ns_o (addr_wait_ns_o),
    .data_wait_ns_o (data_wait_ns_o),
    .last_o         (last_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  mnfw_checker checker_i (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_i     (in_stall_o),
    .midi_byte_i    (midi_byte_i),
    .out_valid_i    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .reg_addr_i     (reg_addr_o),
    .reg_data_i     (reg_data_o),
    .port_high_i    (port_high_o),
    .addr_wait_ns_i (addr_wait_ns_o),
    .data_wait_ns_i (data_wait_ns_o),
    .last_i         (last_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .pending_o      (pending_writes),
    .fail_count_o   (fail_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  // write side: stall a random number of cycles before each beat
  initial begin
    int unsigned hold;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      if ($urandom_range(0, 29) == 0) recv_quiet = !recv_quiet;
      hold = recv_quiet ? 0 : $urandom_range(0, 5);
      if (hold != 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o || out_stall_i);
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    if ($urandom_range(0, 19) == 0) send_quiet = !send_quiet;
    gap = send_quiet ? 0 : $urandom_range(0, 5);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    midi_byte_i <= b;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic note_sequence(input logic [6:0] key, input logic [6:0] vel);
    send_byte(MidiNoteOn);
    send_byte({1'b0, key});
    send_byte({1'b0, vel});
  endtask

  // wait out every queued write, then the cycles a silent byte may still take
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_writes != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
  endtask

  task automatic load_patch(input logic [63:0] w0, input logic [63:0] w1,
                            input logic [63:0] w2, input logic [63:0] w3,
                            input logic [47:0] w4);
    cfg_write(CfgPatch0, w0);
    cfg_write(CfgPatch1, w1);
    cfg_write(CfgPatch2, w2);
    cfg_write(CfgPatch3, w3);
    cfg_write(CfgPatch4, {16'h0000, w4});
    cfg_we_i <= 1'b0;
  endtask

  task automatic play_random_sequence(inout int unsigned counted);
    int unsigned pick;
    logic [6:0]  key;
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      key = 7'($urandom_range(KeyLow, KeyHigh));
      note_sequence(key, 7'($urandom_range(1, 127)));
      recent_keys.push_back(key);
      if (recent_keys.size() > 8) void'(recent_keys.pop_front());
      counted += 3;
    end else if (pick < 78) begin
      // release: mostly a recently played key, sometimes any key
      if (recent_keys.size() != 0 && $urandom_range(0, 3) != 0)
        key = recent_keys[$urandom_range(0, recent_keys.size() - 1)];
      else
        key = 7'($urandom_range(0, 127));
      note_sequence(key, 7'd0);
      counted += 3;
    end else if (pick < 86) begin
      if ($urandom_range(0, 1) != 0) key = 7'($urandom_range(0, KeyLow - 1));
      else key = 7'($urandom_range(KeyHigh + 1, 127));
      note_sequence(key, 7'($urandom_range(1, 127)));
      counted += 3;
    end else if (pick < 94) begin
      // broken sequence: status or sensing byte between key and velocity
      send_byte(MidiNoteOn);
      send_byte(8'($urandom_range(0, 127)));
      case ($urandom_range(0, 2))
        0:       send_byte(MidiNoteOff);
        1:       send_byte(MidiNoteOn);
        default: send_byte(MidiSense);
      endcase
      send_byte(8'($urandom_range(0, 127)));
      counted += 4;
    end else begin
      send_byte(8'($urandom_range(0, 255)));
      counted += 1;
    end
  endtask

  initial begin
    int unsigned counted;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    midi_byte_i = '0;
    cfg_we_i    = 1'b0;
    cfg_index_i = CfgPatch0;
    cfg_data_i  = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    load_patch({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
               {$urandom, $urandom}, 48'({$urandom, $urandom}));
    send_byte(MidiSense);
    send_byte(8'd200);
    send_byte(8'd5);
    note_sequence(7'd0, 7'd0);
    note_sequence(KeyLow, 7'd127);
    note_sequence(KeyHigh, 7'd1);
    note_sequence(KeyLow - 7'd1, 7'd64);
    note_sequence(7'd127, 7'd64);
    send_byte(MidiNoteOn);
    send_byte(8'd60);
    send_byte(MidiNoteOff);
    send_byte(MidiNoteOn);
    note_sequence(7'd70, 7'd90);
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       load_patch('1, '1, '1, '1, '1);
        1:       load_patch('0, '0, '0, '0, '0);
        default: load_patch({$urandom, $urandom}, {$urandom, $urandom},
                            {$urandom, $urandom}, {$urandom, $urandom},
                            48'({$urandom, $urandom}));
      endcase
      counted = 0;
      while (counted < PhaseItems) play_random_sequence(counted);
      drain();
    end

    if (fail_count == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
src/mnfw_pkg.sv
src/mnfw_ctrl.sv
src/mnfw_dp.sv
src/midi_note_to_fm_register_writer_top.sv
src/mnfw_chk.sv
test/mnfw_checker.sv
test/testbench.sv
